// ===== src/avtpc_pkg.sv =====
// ----------------------------------------------------------------------------
// avtpc_pkg
// Shared types and constants of the AVTP control frame parser.
// ----------------------------------------------------------------------------
package avtpc_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_PLAIN_SUBTYPE = 2'd0;
	localparam logic [1:0] REG_TIMED_SUBTYPE = 2'd1;
	localparam logic [1:0] REG_TIME_SYNC_ON  = 2'd2;

	localparam int PLAIN_HDR = 12;
	localparam int TIMED_HDR = 24;

	// result queue
	localparam int QDEPTH = 8;
	localparam int QPTR_W = 3;
	localparam int QCNT_W = 4;

	typedef enum logic [1:0] {
		CLS_BAD   = 2'd0,
		CLS_PLAIN = 2'd1,
		CLS_TIMED = 2'd2,
		CLS_DROP  = 2'd3
	} frame_class_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_SHORT_HDR  = 3'd1,
		ST_BAD_SUB    = 3'd2,
		ST_DROPPED    = 3'd3,
		ST_SHORT_DATA = 3'd4
	} status_t;

	typedef struct packed {
		logic        item_kind;
		logic [7:0]  payload_byte;
		logic [2:0]  status;
		logic        format;
		logic [3:0]  flag_bits;
		logic [2:0]  version;
		logic [7:0]  sequence_number;
		logic [63:0] stream_ident;
		logic [31:0] timestamp;
		logic [15:0] data_length;
		logic        run_last;
	} result_t;

	// results produced by one byte
	typedef struct packed {
		logic pay;
		logic stat;
	} push_t;

endpackage

// ===== src/avtpc_parse.sv =====
// ----------------------------------------------------------------------------
// avtpc_parse
// Header field capture and result build for one frame byte per cycle.
// ----------------------------------------------------------------------------
module avtpc_parse #(
	parameter int INDEX_BITS = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  logic [7:0]          byte_s1,
	input  logic                end_s1,
	input  logic [7:0]          plain_subtype_q,
	input  logic [7:0]          timed_subtype_q,
	input  logic                time_sync_on_q,
	output avtpc_pkg::push_t    push,
	output avtpc_pkg::result_t  pay_res,
	output avtpc_pkg::result_t  stat_res
);

	localparam int IW = INDEX_BITS;

	logic [IW-1:0]          idx_q;
	avtpc_pkg::frame_class_t cls_q;
	logic [3:0]             flags_q;
	logic [2:0]             ver_q;
	logic [7:0]             seq_q;
	logic [63:0]            stream_q;
	logic [31:0]            time_q;
	logic [15:0]            len_q;

	avtpc_pkg::frame_class_t cls_n;
	logic [3:0]             flags_n;
	logic [2:0]             ver_n;
	logic [7:0]             seq_n;
	logic [63:0]            stream_n;
	logic [31:0]            time_n;
	logic [15:0]            len_n;
	logic [IW-1:0]          idx_n;
	logic                   timed;
	logic [IW:0]            hdr;
	logic [IW:0]            pos_x;
	logic [IW:0]            data_end;
	logic [IW:0]            len_tot;
	avtpc_pkg::status_t     st;
	logic                   first;

	always_comb begin
		first = (idx_q == '0);
		pos_x = {1'b0, idx_q};

		if (first) begin
			if (byte_s1 == plain_subtype_q) begin
				cls_n = avtpc_pkg::CLS_PLAIN;
			end else if (byte_s1 == timed_subtype_q) begin
				cls_n = time_sync_on_q ? avtpc_pkg::CLS_TIMED : avtpc_pkg::CLS_DROP;
			end else begin
				cls_n = avtpc_pkg::CLS_BAD;
			end
			flags_n  = '0;
			ver_n    = '0;
			seq_n    = '0;
			stream_n = '0;
			time_n   = '0;
			len_n    = '0;
		end else begin
			cls_n    = cls_q;
			flags_n  = flags_q;
			ver_n    = ver_q;
			seq_n    = seq_q;
			stream_n = stream_q;
			time_n   = time_q;
			len_n    = len_q;
		end

		timed = (cls_n == avtpc_pkg::CLS_TIMED) || (cls_n == avtpc_pkg::CLS_DROP);
		hdr   = timed ? (IW+1)'(avtpc_pkg::TIMED_HDR) : (IW+1)'(avtpc_pkg::PLAIN_HDR);

		if (cls_n == avtpc_pkg::CLS_PLAIN) begin
			if (idx_q == IW'(1)) begin
				flags_n = {byte_s1[7], 3'b000};
				ver_n   = byte_s1[6:4];
				len_n   = {5'd0, byte_s1[2:0], len_n[7:0]};
			end else if (idx_q == IW'(2)) begin
				len_n = {len_n[15:8], byte_s1};
			end else if (idx_q == IW'(3)) begin
				seq_n = byte_s1;
			end
		end else if (timed) begin
			if (idx_q == IW'(1)) begin
				flags_n = {byte_s1[7], byte_s1[3], byte_s1[0], flags_n[0]};
				ver_n   = byte_s1[6:4];
			end else if (idx_q == IW'(2)) begin
				seq_n = byte_s1;
			end else if (idx_q == IW'(3)) begin
				flags_n = {flags_n[3:1], byte_s1[0]};
			end else if (idx_q >= IW'(12) && idx_q <= IW'(15)) begin
				time_n = {time_n[23:0], byte_s1};
			end else if (idx_q == IW'(20)) begin
				len_n = {byte_s1, len_n[7:0]};
			end else if (idx_q == IW'(21)) begin
				len_n = {len_n[15:8], byte_s1};
			end
		end
		if (cls_n != avtpc_pkg::CLS_BAD && idx_q >= IW'(4) && idx_q <= IW'(11)) begin
			stream_n = {stream_n[55:0], byte_s1};
		end

		data_end = hdr + (IW+1)'(len_n);
		len_tot  = pos_x + (IW+1)'(1);

		// status checks in priority order
		priority if (len_tot < hdr) begin
			st = avtpc_pkg::ST_SHORT_HDR;
		end else if (cls_n == avtpc_pkg::CLS_BAD) begin
			st = avtpc_pkg::ST_BAD_SUB;
		end else if (cls_n == avtpc_pkg::CLS_DROP) begin
			st = avtpc_pkg::ST_DROPPED;
		end else if (len_tot < data_end) begin
			st = avtpc_pkg::ST_SHORT_DATA;
		end else begin
			st = avtpc_pkg::ST_OK;
		end

		push.pay  = valid_s1 &&
			(cls_n == avtpc_pkg::CLS_PLAIN || cls_n == avtpc_pkg::CLS_TIMED) &&
			pos_x >= hdr && pos_x < data_end;
		push.stat = valid_s1 && end_s1;

		pay_res              = '0;
		pay_res.payload_byte = byte_s1;
		pay_res.run_last     = !end_s1;

		stat_res           = '0;
		stat_res.item_kind = 1'b1;
		stat_res.status    = st;
		stat_res.format    = timed;
		stat_res.run_last  = 1'b1;
		if (st == avtpc_pkg::ST_OK || st == avtpc_pkg::ST_SHORT_DATA) begin
			stat_res.flag_bits       = flags_n;
			stat_res.version         = ver_n;
			stat_res.sequence_number = seq_n;
			stat_res.stream_ident    = stream_n;
			stat_res.timestamp       = time_n;
			stat_res.data_length     = len_n;
		end

		// saturate on overlong frames
		idx_n = (&idx_q) ? idx_q : idx_q + IW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			cls_q    <= avtpc_pkg::CLS_BAD;
			flags_q  <= '0;
			ver_q    <= '0;
			seq_q    <= '0;
			stream_q <= '0;
			time_q   <= '0;
			len_q    <= '0;
		end else if (valid_s1) begin
			if (end_s1) begin
				idx_q    <= '0;
				cls_q    <= avtpc_pkg::CLS_BAD;
				flags_q  <= '0;
				ver_q    <= '0;
				seq_q    <= '0;
				stream_q <= '0;
				time_q   <= '0;
				len_q    <= '0;
			end else begin
				idx_q    <= idx_n;
				cls_q    <= cls_n;
				flags_q  <= flags_n;
				ver_q    <= ver_n;
				seq_q    <= seq_n;
				stream_q <= stream_n;
				time_q   <= time_n;
				len_q    <= len_n;
			end
		end
	end

	// a dropped or bad frame never forwards payload
	a_no_pay_suppressed: assert property (@(posedge clk) disable iff (!arst_n)
		(cls_n == avtpc_pkg::CLS_BAD || cls_n == avtpc_pkg::CLS_DROP) |-> !push.pay)
		else $error("payload pushed for a suppressed frame");

	// the frame state is back to the start after the closing beat
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && end_s1) |=> (idx_q == '0 && len_q == '0))
		else $error("frame state not cleared after end of frame");

endmodule

// ===== src/avtpc_rq.sv =====
// ----------------------------------------------------------------------------
// avtpc_rq
// Result queue: takes up to two results a cycle, hands out one a cycle when popped.
// ----------------------------------------------------------------------------
module avtpc_rq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  avtpc_pkg::push_t                  push,
	input  avtpc_pkg::result_t                pay_res,
	input  avtpc_pkg::result_t                stat_res,
	input  logic                              pop,
	output avtpc_pkg::result_t                head,
	output logic                              head_valid,
	output logic [avtpc_pkg::QCNT_W-1:0]      cnt
);

	localparam int PW = avtpc_pkg::QPTR_W;
	localparam int CW = avtpc_pkg::QCNT_W;

	avtpc_pkg::result_t mem_q [avtpc_pkg::QDEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CW-1:0]      cnt_q;
	logic [PW-1:0]      stat_ptr;
	logic [CW-1:0]      n_push;

	assign stat_ptr   = wr_ptr_q + PW'(push.pay);
	assign n_push     = CW'(push.pay) + CW'(push.stat);
	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (cnt_q != '0);
	assign cnt        = cnt_q;

	always_ff @(posedge clk) begin
		if (push.pay) begin
			mem_q[wr_ptr_q] <= pay_res;
		end
		if (push.stat) begin
			mem_q[stat_ptr] <= stat_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + n_push - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cnt_q) + 32'(n_push) - 32'(pop)) <= avtpc_pkg::QDEPTH)
		else $error("result queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("result queue underflow");

	// with two results from one byte only the status closes the run
	a_run_last_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(push.pay && push.stat) |-> (!pay_res.run_last && stat_res.run_last))
		else $error("run_last wrong on paired results");

endmodule

// ===== src/avtp_control_frame_parser_unit.sv =====
// ----------------------------------------------------------------------------
// avtp_control_frame_parser_unit
// Streaming NTSCF/TSCF header parser: frame bytes in, payload bytes and one
// end-of-frame status beat out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | frame_byte, frame_end
//  out     | output    | out_valid/out_stall | item_kind .. run_last
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
//  One byte per cycle while in_stall is low; a byte is registered, then queued.
//  A byte can give two beats (last payload byte and status), so results go
//  through an 8-deep queue; in_stall rises when the queue could not hold two
//  results for both the byte in flight and a new one.
//  Reset clears the subtype registers to their defaults and the frame state.
// ----------------------------------------------------------------------------
module avtp_control_frame_parser_unit #(
	parameter int INDEX_BITS = 17
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  frame_byte,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        item_kind,
	output logic [7:0]  payload_byte,
	output logic [2:0]  status,
	output logic        format,
	output logic [3:0]  flag_bits,
	output logic [2:0]  version,
	output logic [7:0]  sequence_number,
	output logic [63:0] stream_ident,
	output logic [31:0] timestamp,
	output logic [15:0] data_length,
	output logic        run_last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int CW = avtpc_pkg::QCNT_W;

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               end_s1;
	logic [7:0]         plain_subtype_q;
	logic [7:0]         timed_subtype_q;
	logic               time_sync_on_q;
	avtpc_pkg::push_t   push;
	avtpc_pkg::result_t pay_res;
	avtpc_pkg::result_t stat_res;
	avtpc_pkg::result_t head;
	logic [CW-1:0]      cnt;
	logic [CW:0]        committed;
	logic               in_take;

	assign committed = {1'b0, cnt} + {{(CW-1){1'b0}}, valid_s1, 1'b0};
	assign in_stall  = committed > (CW+1)'(avtpc_pkg::QDEPTH - 2);
	assign in_take   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= frame_byte;
			end_s1  <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plain_subtype_q <= 8'd130;
			timed_subtype_q <= 8'd2;
			time_sync_on_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				avtpc_pkg::REG_PLAIN_SUBTYPE: plain_subtype_q <= cfg_data;
				avtpc_pkg::REG_TIMED_SUBTYPE: timed_subtype_q <= cfg_data;
				avtpc_pkg::REG_TIME_SYNC_ON:  time_sync_on_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	avtpc_parse #(
		.INDEX_BITS(INDEX_BITS)
	) u_parse (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid_s1        (valid_s1),
		.byte_s1         (byte_s1),
		.end_s1          (end_s1),
		.plain_subtype_q (plain_subtype_q),
		.timed_subtype_q (timed_subtype_q),
		.time_sync_on_q  (time_sync_on_q),
		.push            (push),
		.pay_res         (pay_res),
		.stat_res        (stat_res)
	);

	avtpc_rq u_rq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pay_res    (pay_res),
		.stat_res   (stat_res),
		.pop        (out_valid && !out_stall),
		.head       (head),
		.head_valid (out_valid),
		.cnt        (cnt)
	);

	assign item_kind       = head.item_kind;
	assign payload_byte    = head.payload_byte;
	assign status          = head.status;
	assign format          = head.format;
	assign flag_bits       = head.flag_bits;
	assign version         = head.version;
	assign sequence_number = head.sequence_number;
	assign stream_ident    = head.stream_ident;
	assign timestamp       = head.timestamp;
	assign data_length     = head.data_length;
	assign run_last        = head.run_last;

	// an accepted beat always finds room for its results
	a_room_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |-> committed <= (CW+1)'(avtpc_pkg::QDEPTH - 2))
		else $error("byte accepted without queue room");

endmodule
